FILE: rtl/che_pkg.sv
// shared widths, codes and register indexes of the cubic hermite curve evaluator
package che_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int U_FRAC_BITS     = 16;
    localparam int U_WIDTH         = U_FRAC_BITS + 1;
    localparam int U2_WIDTH        = U_FRAC_BITS + 2;
    localparam int U3_WIDTH        = U_FRAC_BITS + 3;
    localparam int WEIGHT_WIDTH    = U_FRAC_BITS + 7;
    localparam int PROD_WIDTH      = WEIGHT_WIDTH + COORD_WIDTH;
    localparam int SUM_WIDTH       = PROD_WIDTH + 2;
    localparam int OUT_WIDTH       = 19;
    localparam int NUM_REGS        = 8;
    localparam int REG_INDEX_WIDTH = $clog2(NUM_REGS);
    localparam int NUM_TERMS       = 4;

    typedef enum logic
    {
        OP_POSITION   = 1'b0,
        OP_DERIVATIVE = 1'b1
    } op_t;

    typedef enum logic [REG_INDEX_WIDTH-1:0]
    {
        REG_START_X         = 3'd0,
        REG_START_Y         = 3'd1,
        REG_END_X           = 3'd2,
        REG_END_Y           = 3'd3,
        REG_START_TANGENT_X = 3'd4,
        REG_START_TANGENT_Y = 3'd5,
        REG_END_TANGENT_X   = 3'd6,
        REG_END_TANGENT_Y   = 3'd7
    } cfg_reg_t;

endpackage

FILE: rtl/che_if.sv
// valid/ready channels of the curve evaluator: parameter words in, result words out
interface che_in_if import che_pkg::*; ();
    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [U_WIDTH-1:0]   param_u;

    modport source (output valid, output op, output param_u, input ready);
    modport sink   (input valid, input op, input param_u, output ready);
endinterface

interface che_out_if import che_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] result_x;
    logic signed [OUT_WIDTH-1:0] result_y;

    modport source (output valid, output result_x, output result_y, input ready);
    modport sink   (input valid, input result_x, input result_y, output ready);
endinterface

FILE: rtl/cubic_hermite_curve_eval.sv
// cubic hermite segment evaluator: six-stage pipeline from parameter u to x/y result
//
//  channel     dir  handshake      payload
//  param_in    in   valid/ready    op, param_u (unsigned q1.16)
//  curve_out   out  valid/ready    result_x, result_y (signed q15.4)
//  cfg         in   cfg_we         cfg_index, cfg_data (signed q12.4)
//
// one word per cycle sustained while curve_out.ready stays high; a word accepted on param_in
// passes six register stages (square, cube, basis weights, coord products, sum,
// round/saturate) before it shows on curve_out.valid
// rst_n clears the eight control point registers to zero and empties the pipeline
// every stage has its own valid bit and takes a new word when it is empty or its
// successor takes its word, so bubbles collapse during a stall and nothing is lost
module cubic_hermite_curve_eval
    import che_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    che_in_if.sink                        param_in,
    che_out_if.source                     curve_out,
    input  logic                          cfg_we,
    input  cfg_reg_t                      cfg_index,
    input  logic signed [COORD_WIDTH-1:0] cfg_data
);

    localparam int STAGES = 6;
    localparam logic [U_WIDTH-1:0] U_ONE = U_WIDTH'(1) << U_FRAC_BITS;
    localparam logic signed [SUM_WIDTH-1:0] SAT_HI = SUM_WIDTH'((1 << (OUT_WIDTH - 1)) - 1);
    localparam logic signed [SUM_WIDTH-1:0] SAT_LO = -SUM_WIDTH'(1 << (OUT_WIDTH - 1));

    // control point registers
    logic signed [COORD_WIDTH-1:0] coord_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coord_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            coord_reg[cfg_index] <= cfg_data;
        end
    end

    // per-stage valid bits and ready chain from the output back
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] stage_ready;
    logic [STAGES-1:0] stage_load;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] valid_in;

    assign valid_in = {valid_reg[STAGES-2:0], param_in.valid};

    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || curve_out.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        stage_load = stage_ready & valid_in;
        for (int k = 0; k < STAGES; k++)
        begin
            valid_next[k] = stage_ready[k] ? valid_in[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign param_in.ready  = stage_ready[0];
    assign curve_out.valid = valid_reg[STAGES-1];

    // stage 1: u squared
    logic [U_WIDTH-1:0]    u_s1_reg;
    logic [U2_WIDTH-1:0]   u2_s1_reg;
    op_t                   op_s1_reg;
    logic [2*U_WIDTH-1:0]  square_full;
    logic [U2_WIDTH-1:0]   u2_s1_next;

    always_comb
    begin
        square_full = param_in.param_u * param_in.param_u;
        u2_s1_next  = square_full[U_FRAC_BITS +: U2_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            u_s1_reg  <= param_in.param_u;
            u2_s1_reg <= u2_s1_next;
            op_s1_reg <= param_in.op;
        end
    end

    // stage 2: u cubed
    logic [U_WIDTH-1:0]            u_s2_reg;
    logic [U2_WIDTH-1:0]           u2_s2_reg;
    logic [U3_WIDTH-1:0]           u3_s2_reg;
    op_t                           op_s2_reg;
    logic [U2_WIDTH+U_WIDTH-1:0]   cube_full;
    logic [U3_WIDTH-1:0]           u3_s2_next;

    always_comb
    begin
        cube_full  = u2_s1_reg * u_s1_reg;
        u3_s2_next = cube_full[U_FRAC_BITS +: U3_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[1])
        begin
            u_s2_reg  <= u_s1_reg;
            u2_s2_reg <= u2_s1_reg;
            u3_s2_reg <= u3_s2_next;
            op_s2_reg <= op_s1_reg;
        end
    end

    // stage 3: basis weights for position or derivative
    logic signed [WEIGHT_WIDTH-1:0] weight_s3_reg  [NUM_TERMS];
    logic signed [WEIGHT_WIDTH-1:0] weight_s3_next [NUM_TERMS];
    logic signed [WEIGHT_WIDTH-1:0] wu, wu2, wu3, wone;

    always_comb
    begin
        wu   = $signed(WEIGHT_WIDTH'(u_s2_reg));
        wu2  = $signed(WEIGHT_WIDTH'(u2_s2_reg));
        wu3  = $signed(WEIGHT_WIDTH'(u3_s2_reg));
        wone = $signed(WEIGHT_WIDTH'(U_ONE));
        case (op_s2_reg)
            OP_POSITION:
            begin
                weight_s3_next[0] = (wu3 <<< 1) - ((wu2 <<< 1) + wu2) + wone;
                weight_s3_next[1] = ((wu2 <<< 1) + wu2) - (wu3 <<< 1);
                weight_s3_next[2] = wu3 - (wu2 <<< 1) + wu;
                weight_s3_next[3] = wu3 - wu2;
            end
            default:
            begin
                weight_s3_next[0] = ((wu2 <<< 2) + (wu2 <<< 1)) - ((wu <<< 2) + (wu <<< 1));
                weight_s3_next[1] = ((wu <<< 2) + (wu <<< 1)) - ((wu2 <<< 2) + (wu2 <<< 1));
                weight_s3_next[2] = ((wu2 <<< 1) + wu2) - (wu <<< 2) + wone;
                weight_s3_next[3] = ((wu2 <<< 1) + wu2) - (wu <<< 1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[2])
        begin
            weight_s3_reg <= weight_s3_next;
        end
    end

    // stage 4: weight times control coordinate, four terms per axis
    logic signed [COORD_WIDTH-1:0] coord_x [NUM_TERMS];
    logic signed [COORD_WIDTH-1:0] coord_y [NUM_TERMS];
    logic signed [PROD_WIDTH-1:0]  prod_x_s4_reg  [NUM_TERMS];
    logic signed [PROD_WIDTH-1:0]  prod_y_s4_reg  [NUM_TERMS];
    logic signed [PROD_WIDTH-1:0]  prod_x_s4_next [NUM_TERMS];
    logic signed [PROD_WIDTH-1:0]  prod_y_s4_next [NUM_TERMS];

    always_comb
    begin
        coord_x[0] = coord_reg[REG_START_X];
        coord_x[1] = coord_reg[REG_END_X];
        coord_x[2] = coord_reg[REG_START_TANGENT_X];
        coord_x[3] = coord_reg[REG_END_TANGENT_X];
        coord_y[0] = coord_reg[REG_START_Y];
        coord_y[1] = coord_reg[REG_END_Y];
        coord_y[2] = coord_reg[REG_START_TANGENT_Y];
        coord_y[3] = coord_reg[REG_END_TANGENT_Y];
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            prod_x_s4_next[t] = PROD_WIDTH'(weight_s3_reg[t]) * PROD_WIDTH'(coord_x[t]);
            prod_y_s4_next[t] = PROD_WIDTH'(weight_s3_reg[t]) * PROD_WIDTH'(coord_y[t]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[3])
        begin
            prod_x_s4_reg <= prod_x_s4_next;
            prod_y_s4_reg <= prod_y_s4_next;
        end
    end

    // stage 5: sum of the four terms
    logic signed [SUM_WIDTH-1:0] sum_x_s5_reg, sum_y_s5_reg;
    logic signed [SUM_WIDTH-1:0] sum_x_s5_next, sum_y_s5_next;

    always_comb
    begin
        sum_x_s5_next = SUM_WIDTH'(prod_x_s4_reg[0]) + SUM_WIDTH'(prod_x_s4_reg[1])
                      + SUM_WIDTH'(prod_x_s4_reg[2]) + SUM_WIDTH'(prod_x_s4_reg[3]);
        sum_y_s5_next = SUM_WIDTH'(prod_y_s4_reg[0]) + SUM_WIDTH'(prod_y_s4_reg[1])
                      + SUM_WIDTH'(prod_y_s4_reg[2]) + SUM_WIDTH'(prod_y_s4_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[4])
        begin
            sum_x_s5_reg <= sum_x_s5_next;
            sum_y_s5_reg <= sum_y_s5_next;
        end
    end

    // stage 6: floor shift back to q.4 and clamp to the output range
    logic signed [SUM_WIDTH-1:0] shift_x, shift_y;
    logic signed [OUT_WIDTH-1:0] result_x_reg, result_y_reg;
    logic signed [OUT_WIDTH-1:0] result_x_next, result_y_next;

    always_comb
    begin
        // arithmetic shift rounds toward minus infinity
        shift_x = sum_x_s5_reg >>> U_FRAC_BITS;
        shift_y = sum_y_s5_reg >>> U_FRAC_BITS;
        if (shift_x > SAT_HI)
        begin
            result_x_next = SAT_HI[OUT_WIDTH-1:0];
        end
        else if (shift_x < SAT_LO)
        begin
            result_x_next = SAT_LO[OUT_WIDTH-1:0];
        end
        else
        begin
            result_x_next = shift_x[OUT_WIDTH-1:0];
        end
        if (shift_y > SAT_HI)
        begin
            result_y_next = SAT_HI[OUT_WIDTH-1:0];
        end
        else if (shift_y < SAT_LO)
        begin
            result_y_next = SAT_LO[OUT_WIDTH-1:0];
        end
        else
        begin
            result_y_next = shift_y[OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[5])
        begin
            result_x_reg <= result_x_next;
            result_y_reg <= result_y_next;
        end
    end

    assign curve_out.result_x = result_x_reg;
    assign curve_out.result_y = result_y_reg;

endmodule

FILE: test/tb_cubic_hermite_curve_eval.sv
// self-checking testbench of the cubic hermite curve evaluator: directed probes, then random words
module tb_cubic_hermite_curve_eval;
    import che_pkg::*;

    // pipeline depth from the head of the block, used for the settle time at the end
    localparam int PIPE_DEPTH      = 6;
    // cycles with no word moving on either channel before the run is declared hung
    localparam int WATCHDOG_LIMIT  = 3000;
    // length of the long receiver hold-off that fills the pipeline
    localparam int HOLD_CYCLES     = 300;
    localparam int WORDS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 8;
    localparam int NUM_PROBES      = 23;

    localparam logic [U_WIDTH-1:0] U_ONE  = U_WIDTH'(1) << U_FRAC_BITS;
    localparam logic [U_WIDTH-1:0] U_HALF = U_WIDTH'(1) << (U_FRAC_BITS - 1);
    localparam logic [U_WIDTH-1:0] U_MAX  = '1;

    // one coordinate per control register, indexed by cfg_reg_t
    typedef logic [NUM_REGS-1:0][COORD_WIDTH-1:0] coord_set_t;
    typedef longint basis_t [NUM_TERMS];

    typedef struct packed
    {
        logic signed [OUT_WIDTH-1:0] x;
        logic signed [OUT_WIDTH-1:0] y;
    } curve_word_t;

    // one directed probe: which segment is loaded, the input word, and the
    // result where it can be stated outright (known = 1)
    typedef struct packed
    {
        logic [3:0]                  seg;
        op_t                         op;
        logic [U_WIDTH-1:0]          u;
        logic                        known;
        logic signed [OUT_WIDTH-1:0] ex;
        logic signed [OUT_WIDTH-1:0] ey;
    } probe_row_t;

    // segment 0 is the reset state, 1 a plain mixed segment, 2 a segment whose
    // terms all push x up and y down far past one, 3 every coordinate at its minimum,
    // 4 every coordinate at its maximum
    localparam probe_row_t PROBES [NUM_PROBES] = '{
        // after reset all control points are zero
        '{0, OP_POSITION,   0,         1, 0, 0},
        '{0, OP_DERIVATIVE, U_MAX,     1, 0, 0},
        // u = 0 and u = 1 land exactly on the end points and tangents
        '{1, OP_POSITION,   0,         1, 100, -200},
        '{1, OP_POSITION,   U_ONE,     1, -3000, 4000},
        '{1, OP_DERIVATIVE, 0,         1, 1234, -567},
        '{1, OP_DERIVATIVE, U_ONE,     1, -890, 321},
        '{1, OP_POSITION,   U_HALF,    0, 0, 0},
        '{1, OP_DERIVATIVE, U_HALF,    0, 0, 0},
        '{1, OP_POSITION,   1,         0, 0, 0},
        '{1, OP_DERIVATIVE, U_ONE - 1, 0, 0, 0},
        // u just above one and at the top of its field
        '{1, OP_POSITION,   U_ONE + 1, 0, 0, 0},
        '{1, OP_DERIVATIVE, U_MAX,     0, 0, 0},
        // far past one the sums leave the output range: both rails in the first row
        '{2, OP_POSITION,   U_MAX,     1, 262143, -262144},
        '{2, OP_POSITION,   0,         1, 32767, -32768},
        '{2, OP_POSITION,   U_ONE,     1, -32768, 32767},
        '{2, OP_DERIVATIVE, 0,         1, 32767, -32768},
        '{2, OP_DERIVATIVE, U_MAX,     0, 0, 0},
        '{3, OP_POSITION,   0,         1, -32768, -32768},
        '{3, OP_POSITION,   U_ONE,     1, -32768, -32768},
        '{3, OP_DERIVATIVE, U_MAX,     0, 0, 0},
        '{4, OP_DERIVATIVE, U_ONE,     1, 32767, 32767},
        '{4, OP_POSITION,   U_MAX,     0, 0, 0},
        '{4, OP_DERIVATIVE, U_HALF,    0, 0, 0}
    };

    logic clk;
    logic rst_n;
    logic                          cfg_we;
    cfg_reg_t                      cfg_index;
    logic signed [COORD_WIDTH-1:0] cfg_data;

    che_in_if  param_ch ();
    che_out_if result_ch ();

    cubic_hermite_curve_eval u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .param_in  (param_ch),
        .curve_out (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the control registers as the block should hold them
    logic signed [COORD_WIDTH-1:0] ctl [NUM_REGS];
    // results owed by the block, oldest first
    curve_word_t pending_words [$];

    int err_count       = 0;
    int words_sent      = 0;
    int results_seen    = 0;
    int segments_loaded = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_len        = 0;
    int stall_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic coord_set_t make_set(input int p0x, input int p0y, input int p1x,
                                            input int p1y, input int t0x, input int t0y,
                                            input int t1x, input int t1y);
        coord_set_t s;
        s[REG_START_X]         = COORD_WIDTH'(p0x);
        s[REG_START_Y]         = COORD_WIDTH'(p0y);
        s[REG_END_X]           = COORD_WIDTH'(p1x);
        s[REG_END_Y]           = COORD_WIDTH'(p1y);
        s[REG_START_TANGENT_X] = COORD_WIDTH'(t0x);
        s[REG_START_TANGENT_Y] = COORD_WIDTH'(t0y);
        s[REG_END_TANGENT_X]   = COORD_WIDTH'(t1x);
        s[REG_END_TANGENT_Y]   = COORD_WIDTH'(t1y);
        return s;
    endfunction

    function automatic coord_set_t probe_set(input logic [3:0] seg);
        case (seg)
            1:       return make_set(100, -200, -3000, 4000, 1234, -567, -890, 321);
            2:       return make_set(32767, -32768, -32768, 32767,
                                     32767, -32768, 32767, -32768);
            3:       return make_set(-32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768);
            default: return make_set(32767, 32767, 32767, 32767,
                                     32767, 32767, 32767, 32767);
        endcase
    endfunction

    // weighted sum of the four control coordinates, floored back to q.4
    function automatic longint blend(input basis_t w, input logic signed [COORD_WIDTH-1:0] a,
                                     input logic signed [COORD_WIDTH-1:0] b,
                                     input logic signed [COORD_WIDTH-1:0] c,
                                     input logic signed [COORD_WIDTH-1:0] d);
        longint acc;
        acc = w[0] * longint'(a) + w[1] * longint'(b) + w[2] * longint'(c)
            + w[3] * longint'(d);
        return acc >>> U_FRAC_BITS;
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] clamp_out(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[OUT_WIDTH-1:0];
    endfunction

    // hermite basis at u (position or slope), applied to x and y separately
    function automatic curve_word_t eval_curve(input op_t o, input logic [U_WIDTH-1:0] u);
        longint      uu;
        longint      u2;
        longint      u3;
        longint      one;
        basis_t      w;
        curve_word_t r;
        uu  = longint'(u);
        u2  = (uu * uu) >>> U_FRAC_BITS;
        u3  = (u2 * uu) >>> U_FRAC_BITS;
        one = longint'(1) <<< U_FRAC_BITS;
        if (o == OP_POSITION)
        begin
            w[0] = 2 * u3 - 3 * u2 + one;
            w[1] = -2 * u3 + 3 * u2;
            w[2] = u3 - 2 * u2 + uu;
            w[3] = u3 - u2;
        end
        else
        begin
            w[0] = 6 * u2 - 6 * uu;
            w[1] = -6 * u2 + 6 * uu;
            w[2] = 3 * u2 - 4 * uu + one;
            w[3] = 3 * u2 - 2 * uu;
        end
        r.x = clamp_out(blend(w, ctl[REG_START_X], ctl[REG_END_X],
                              ctl[REG_START_TANGENT_X], ctl[REG_END_TANGENT_X]));
        r.y = clamp_out(blend(w, ctl[REG_START_Y], ctl[REG_END_Y],
                              ctl[REG_START_TANGENT_Y], ctl[REG_END_TANGENT_Y]));
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // coordinates lean on the two extremes now and then
    function automatic int rand_coord();
        case ($urandom_range(9))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(31) - 16;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // mostly u inside [0, 1], with the ends and the region past one mixed in
    function automatic logic [U_WIDTH-1:0] rand_param();
        case ($urandom_range(9))
            0:       return '0;
            1:       return U_ONE;
            2:       return U_ONE + 1 + U_WIDTH'($urandom_range(int'(U_ONE) - 2));
            default: return U_WIDTH'($urandom_range(int'(U_ONE)));
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        err_count++;
        $display("mismatch: %s", msg);
    endtask

    // offer one parameter word and hold it until the block takes it; valid
    // stays high on return so back-to-back words need no extra edge
    task automatic send_word(input op_t o, input logic [U_WIDTH-1:0] u, input logic known,
                             input curve_word_t typed);
        param_ch.valid   <= 1'b1;
        param_ch.op      <= o;
        param_ch.param_u <= u;
        do
            @(posedge clk);
        while (param_ch.ready !== 1'b1);
        pending_words.insert(pending_words.size(), known ? typed : eval_curve(o, u));
        words_sent++;
    endtask

    // random sender gap, one coin toss per cycle
    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct)
        begin
            param_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // stop offering and wait until every owed result has come back
    task automatic settle();
        param_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // write all eight control registers back to back, only while idle
    task automatic load_segment(input coord_set_t s);
        cfg_reg_t r;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            r = cfg_reg_t'(i);
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_data  <= s[r];
            @(posedge clk);
            ctl[r] = s[r];
        end
        cfg_we <= 1'b0;
        segments_loaded++;
    endtask

    // ---------------------------------------------------------------- receiver

    // ready is redrawn every cycle outside a hold; a hold request from the main sequence
    // drops it for the requested length so the pipeline backs up into the input
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- checker

    // each result word is matched against the oldest owed word, field by field
    always @(posedge clk)
    begin
        curve_word_t want;
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            results_seen++;
            if (pending_words.size() == 0)
                note_mismatch($sformatf("result word with none owed: x=%0d y=%0d",
                                        result_ch.result_x, result_ch.result_y));
            else
            begin
                want = pending_words.pop_front();
                if (result_ch.result_x !== want.x)
                    note_mismatch($sformatf("result %0d x: got %0d want %0d",
                                            results_seen, result_ch.result_x, want.x));
                if (result_ch.result_y !== want.y)
                    note_mismatch($sformatf("result %0d y: got %0d want %0d",
                                            results_seen, result_ch.result_y, want.y));
            end
        end
    end

    // hang detector: any word moving on either channel restarts the count
    always @(posedge clk)
    begin
        if ((param_ch.valid === 1'b1 && param_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        int          cur_seg;
        curve_word_t typed;
        coord_set_t  seg_set;

        rst_n             = 1'b0;
        param_ch.valid   <= 1'b0;
        param_ch.op      <= OP_POSITION;
        param_ch.param_u <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_START_X;
        cfg_data         <= '0;
        foreach (ctl[i])
            ctl[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed probes, no idling on either side; a new segment is
        // loaded only once the previous one has fully drained
        cur_seg = 0;
        foreach (PROBES[i])
        begin
            if (PROBES[i].seg != cur_seg)
            begin
                settle();
                load_segment(probe_set(PROBES[i].seg));
                cur_seg = PROBES[i].seg;
            end
            typed.x = PROBES[i].ex;
            typed.y = PROBES[i].ey;
            send_word(PROBES[i].op, PROBES[i].u, PROBES[i].known, typed);
        end

        // random phases: idling mode cycles through none, sender only,
        // receiver only and both; the last two phases use the extreme segments
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (p == NUM_PHASES - 2)
                seg_set = probe_set(4'd4);
            else if (p == NUM_PHASES - 1)
                seg_set = probe_set(4'd3);
            else
                seg_set = make_set(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord(), rand_coord(), rand_coord());
            load_segment(seg_set);

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // long receiver hold-off while words keep being offered
                if (p == 2 && n == 40)
                    hold_len = HOLD_CYCLES;
                // sender pause until the pipeline has emptied
                if (p == 1 && n == WORDS_PER_PHASE / 2)
                    settle();
                send_word(op_t'($urandom_range(1)), rand_param(), 1'b0, '0);
                sender_gap();
            end
        end

        // drain, then give the pipeline time to show any stray word
        settle();
        repeat (4 * PIPE_DEPTH) @(posedge clk);
        if (pending_words.size() != 0)
            note_mismatch($sformatf("%0d result words never came", pending_words.size()));

        $display("covered %0d parameter words over %0d segment loads, %0d results compared",
                 words_sent, segments_loaded, results_seen);
        $display("both ops, u from 0 past 1, saturated rails, idle mixes, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
